// ===== rtl/bbd_pkg.sv =====
// Package for the bilinear Bayer demosaic: sizes, register indexes, commands,
// interpolation kinds and the stage-to-stage structs. No dependencies.
package bbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int RAW_BITS   = 12;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = 13;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED_ROW      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RED_COL      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_RED     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_GREEN   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_BLUE    = 3'd6;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [2:0] KIND_COPY  = 3'd0;
    localparam logic [2:0] KIND_PLUS  = 3'd1;
    localparam logic [2:0] KIND_CROSS = 3'd2;
    localparam logic [2:0] KIND_HORIZ = 3'd3;
    localparam logic [2:0] KIND_VERT  = 3'd4;

    // Sum of up to four raw values and the count that goes with it.
    localparam int SUM_BITS = RAW_BITS + 2;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [2:0]          cnt;
    } avg_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } mark_t;

endpackage

// ===== rtl/bbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/bayer_bilinear_demosaic.sv =====
// Bilinear Bayer demosaic top level: counters, line stores, window and the
// arithmetic pipeline. Depends on bbd_pkg and bbd_ram.
//
// Usage: raw pixels enter on the in channel (valid/ready, cmd=0) in raster
// order; after the last pixel of a frame, flush transfers (cmd=1) drain the
// final row plus one pixel. Each transfer that produces a pixel yields one
// RGB result on the out channel (valid/ready) with row_end/frame_end marks.
// Configuration goes through the cfg channel (index, data) while idle.
// The stream lags by one row plus one pixel; inside the block the result of
// a transfer, once accepted, passes the line store read, window shift,
// neighbor sums, gain multiply, and divide and saturate on its way to the
// output register, one register stage each.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single write and read port of each line store, which are touched once per item.
// Reset clears counters, the window and the valid bits and loads register
// defaults; line store contents are left as they are.
// When the receiver stalls, the whole pipeline holds in place; ready falls
// only while the output register is full and not being taken, so nothing is
// lost or repeated.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [11:0]              raw_pixel,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic                     row_end,
    output logic                     frame_end
);
    // ---------------- configuration ----------------
    logic [11:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic        red_row_reg, red_col_reg;
    logic [15:0] gain_r_reg, gain_g_reg, gain_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 13'd480;
            red_row_reg      <= 1'b0;
            red_col_reg      <= 1'b0;
            gain_r_reg       <= 16'd255;
            gain_g_reg       <= 16'd182;
            gain_b_reg       <= 16'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[11:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                REG_RED_ROW:      red_row_reg      <= cfg_data[0];
                REG_RED_COL:      red_col_reg      <= cfg_data[0];
                REG_GAIN_RED:     gain_r_reg       <= cfg_data;
                REG_GAIN_GREEN:   gain_g_reg       <= cfg_data;
                REG_GAIN_BLUE:    gain_b_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective sizes with the clamps applied.
    logic [12:0] w_eff;
    logic [12:0] h_eff;
    always_comb
    begin
        if (frame_width_reg < 12'd2)
            w_eff = 13'd2;
        else if ({1'b0, frame_width_reg} > 13'(MAX_WIDTH))
            w_eff = 13'(MAX_WIDTH);
        else
            w_eff = {1'b0, frame_width_reg};
        h_eff = (frame_height_reg < 13'd2) ? 13'd2 : frame_height_reg;
    end

    // ---------------- pipeline control ----------------
    // Every stage advances together whenever the output register can take data.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // ---------------- stage 0: counters ----------------
    // The input row counter runs one row past the frame height while draining,
    // so it carries one bit more than the height register.
    logic [12:0]       in_col_reg, out_col_reg, out_row_reg;
    logic [ROW_BITS:0] in_row_reg;
    logic        done_in;
    logic        take;        // item changes state
    logic        emit;
    logic [ADDR_BITS-1:0] idx;
    logic [RAW_BITS-1:0]  px;

    assign done_in = (in_row_reg >= {1'b0, h_eff});
    assign take    = in_fire && !(cmd == CMD_FLUSH && !done_in);
    assign idx     = (in_col_reg >= 13'(MAX_WIDTH)) ? ADDR_BITS'(MAX_WIDTH - 1)
                                                    : in_col_reg[ADDR_BITS-1:0];
    assign px      = done_in ? '0 : raw_pixel[RAW_BITS-1:0];
    assign emit    = (in_row_reg >= 14'd1 && in_col_reg >= 13'd1) || in_row_reg >= 14'd2;

    logic up0, dn0, lf0, rt0, rp0, cp0, rend0, fend0;
    assign up0   = out_row_reg != 13'd0;
    assign dn0   = (out_row_reg + 13'd1) < h_eff;
    assign lf0   = out_col_reg != 13'd0;
    assign rt0   = (out_col_reg + 13'd1) < w_eff;
    assign rp0   = out_row_reg[0];
    assign cp0   = out_col_reg[0];
    assign rend0 = !rt0;
    assign fend0 = rend0 && !dn0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (take)
        begin
            if (emit && fend0)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_col_reg + 13'd1 >= w_eff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 14'd1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 13'd1;
                end
                if (emit)
                begin
                    if (rend0)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 13'd1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 13'd1;
                    end
                end
            end
        end
    end

    // Line stores: read at stage 0, data arrives at stage 1, where the
    // write-back happens. A read of the address being written in the same
    // cycle is bypassed (this happens when a new frame starts right behind
    // the item that closed the previous one).
    logic [RAW_BITS-1:0] upper_q, lower_q;
    logic                s1_valid_reg, s1_emit_reg;
    logic [ADDR_BITS-1:0] s1_idx_reg;
    logic [RAW_BITS-1:0]  s1_px_reg;
    logic                 byp_reg;
    logic [RAW_BITS-1:0]  byp_up_reg, byp_lo_reg;
    logic [RAW_BITS-1:0]  upper_rd, lower_rd;

    // A write pending from stage 1 this cycle (computed from stage-1 data).
    logic                 s1_we;
    assign s1_we = adv && s1_valid_reg;

    bbd_ram #(.WIDTH(RAW_BITS), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (s1_we),
        .waddr (s1_idx_reg),
        .wdata (lower_rd),
        .re    (take),
        .raddr (idx),
        .rdata (upper_q)
    );

    bbd_ram #(.WIDTH(RAW_BITS), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (s1_we),
        .waddr (s1_idx_reg),
        .wdata (s1_px_reg),
        .re    (take),
        .raddr (idx),
        .rdata (lower_q)
    );

    // Stage-1 view of the stores, with forwarding from the write that landed
    // on the same address in the cycle the read was issued.
    always_comb
    begin
        if (byp_reg)
        begin
            upper_rd = byp_up_reg;
            lower_rd = byp_lo_reg;
        end
        else
        begin
            upper_rd = upper_q;
            lower_rd = lower_q;
        end
    end

    logic up1_reg, dn1_reg, lf1_reg, rt1_reg, rp1_reg, cp1_reg, rend1_reg, fend1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s1_emit_reg  <= take && emit;
            // Forward when the incoming read hits the address being written now.
            byp_reg      <= take && s1_valid_reg && (s1_idx_reg == idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= idx;
            s1_px_reg  <= px;
            byp_up_reg <= lower_rd;
            byp_lo_reg <= s1_px_reg;
            up1_reg    <= up0;
            dn1_reg    <= dn0;
            lf1_reg    <= lf0;
            rt1_reg    <= rt0;
            rp1_reg    <= rp0;
            cp1_reg    <= cp0;
            rend1_reg  <= rend0;
            fend1_reg  <= fend0;
        end
    end

    // ---------------- stage 2: window ----------------
    logic [RAW_BITS-1:0] win_reg [3][3];  // [column][row]
    logic s2_valid_reg;
    logic up2_reg, dn2_reg, lf2_reg, rt2_reg, rp2_reg, cp2_reg, rend2_reg, fend2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_emit_reg;
            if (s1_valid_reg)
            begin
                win_reg[0]    <= win_reg[1];
                win_reg[1]    <= win_reg[2];
                win_reg[2][0] <= upper_rd;
                win_reg[2][1] <= lower_rd;
                win_reg[2][2] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            up2_reg   <= up1_reg;
            dn2_reg   <= dn1_reg;
            lf2_reg   <= lf1_reg;
            rt2_reg   <= rt1_reg;
            rp2_reg   <= rp1_reg;
            cp2_reg   <= cp1_reg;
            rend2_reg <= rend1_reg;
            fend2_reg <= fend1_reg;
        end
    end

    // ---------------- stage 3: neighbor sums ----------------
    function automatic avg_t gather(
        input logic [2:0] kind,
        input logic up, input logic dn, input logic lf, input logic rt,
        input logic [RAW_BITS-1:0] c, input logic [RAW_BITS-1:0] n,
        input logic [RAW_BITS-1:0] s, input logic [RAW_BITS-1:0] wv,
        input logic [RAW_BITS-1:0] e, input logic [RAW_BITS-1:0] nw,
        input logic [RAW_BITS-1:0] sw, input logic [RAW_BITS-1:0] ne,
        input logic [RAW_BITS-1:0] se);
        avg_t r;
        r.sum = '0;
        r.cnt = '0;
        case (kind)
            KIND_COPY:
            begin
                r.sum = SUM_BITS'(c);
                r.cnt = 3'd1;
            end
            KIND_PLUS:
            begin
                r.sum = (up ? SUM_BITS'(n) : '0) + (dn ? SUM_BITS'(s) : '0)
                      + (lf ? SUM_BITS'(wv) : '0) + (rt ? SUM_BITS'(e) : '0);
                r.cnt = 3'(up) + 3'(dn) + 3'(lf) + 3'(rt);
            end
            KIND_CROSS:
            begin
                r.sum = (up && lf ? SUM_BITS'(nw) : '0) + (dn && lf ? SUM_BITS'(sw) : '0)
                      + (up && rt ? SUM_BITS'(ne) : '0) + (dn && rt ? SUM_BITS'(se) : '0);
                r.cnt = 3'(up && lf) + 3'(dn && lf) + 3'(up && rt) + 3'(dn && rt);
            end
            KIND_HORIZ:
            begin
                r.sum = (lf ? SUM_BITS'(wv) : '0) + (rt ? SUM_BITS'(e) : '0);
                r.cnt = 3'(lf) + 3'(rt);
            end
            KIND_VERT:
            begin
                r.sum = (up ? SUM_BITS'(n) : '0) + (dn ? SUM_BITS'(s) : '0);
                r.cnt = 3'(up) + 3'(dn);
            end
            default: ;
        endcase
        return r;
    endfunction

    logic [2:0] kr, kg, kb;
    always_comb
    begin
        if (rp2_reg == red_row_reg && cp2_reg == red_col_reg)
        begin
            kr = KIND_COPY;  kg = KIND_PLUS;  kb = KIND_CROSS;
        end
        else if (rp2_reg != red_row_reg && cp2_reg != red_col_reg)
        begin
            kr = KIND_CROSS; kg = KIND_PLUS;  kb = KIND_COPY;
        end
        else if (rp2_reg != red_row_reg)
        begin
            kr = KIND_VERT;  kg = KIND_COPY;  kb = KIND_HORIZ;
        end
        else
        begin
            kr = KIND_HORIZ; kg = KIND_COPY;  kb = KIND_VERT;
        end
    end

    avg_t a_r, a_g, a_b;
    assign a_r = gather(kr, up2_reg, dn2_reg, lf2_reg, rt2_reg, win_reg[1][1],
                        win_reg[1][0], win_reg[1][2], win_reg[0][1], win_reg[2][1],
                        win_reg[0][0], win_reg[0][2], win_reg[2][0], win_reg[2][2]);
    assign a_g = gather(kg, up2_reg, dn2_reg, lf2_reg, rt2_reg, win_reg[1][1],
                        win_reg[1][0], win_reg[1][2], win_reg[0][1], win_reg[2][1],
                        win_reg[0][0], win_reg[0][2], win_reg[2][0], win_reg[2][2]);
    assign a_b = gather(kb, up2_reg, dn2_reg, lf2_reg, rt2_reg, win_reg[1][1],
                        win_reg[1][0], win_reg[1][2], win_reg[0][1], win_reg[2][1],
                        win_reg[0][0], win_reg[0][2], win_reg[2][0], win_reg[2][2]);

    avg_t  a_r3_reg, a_g3_reg, a_b3_reg;
    mark_t m3_reg;
    logic  s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_r3_reg <= a_r;
            a_g3_reg <= a_g;
            a_b3_reg <= a_b;
            m3_reg   <= '{row_end: rend2_reg, frame_end: fend2_reg};
        end
    end

    // ---------------- stage 4: gain multiply ----------------
    localparam int PROD_BITS = SUM_BITS + 16;
    logic [PROD_BITS-1:0] p_r4_reg, p_g4_reg, p_b4_reg;
    logic [2:0]           c_r4_reg, c_g4_reg, c_b4_reg;
    mark_t                m4_reg;
    logic                 s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_r4_reg <= PROD_BITS'(a_r3_reg.sum) * PROD_BITS'(gain_r_reg);
            p_g4_reg <= PROD_BITS'(a_g3_reg.sum) * PROD_BITS'(gain_g_reg);
            p_b4_reg <= PROD_BITS'(a_b3_reg.sum) * PROD_BITS'(gain_b_reg);
            c_r4_reg <= a_r3_reg.cnt;
            c_g4_reg <= a_g3_reg.cnt;
            c_b4_reg <= a_b3_reg.cnt;
            m4_reg   <= m3_reg;
        end
    end

    // ---------------- stage 5: divide by count*1024, saturate ----------------
    // Count is 1 to 4. A count of 3 comes from the plus pattern on a frame
    // border and uses a reciprocal multiply: floor(x/3) = (x*0xAAAB)>>17 for x
    // below 2^16; larger quotients saturate anyway.
    localparam int Q_BITS = PROD_BITS - 10;

    function automatic logic [7:0] finish(input logic [PROD_BITS-1:0] p,
                                          input logic [2:0] cnt);
        logic [Q_BITS-1:0] q;
        logic [Q_BITS-1:0] d;
        logic              big;
        logic [16+17-1:0]  m3;
        q   = p[PROD_BITS-1:10];
        d   = '0;
        big = 1'b0;
        m3  = '0;
        case (cnt)
            3'd1: d = q;
            3'd2: d = q >> 1;
            3'd4: d = q >> 2;
            3'd3:
            begin
                big = |q[Q_BITS-1:16];
                m3  = 33'(q[15:0]) * 33'h0AAAB;
                d   = big ? '1 : Q_BITS'(m3[32:17]);
            end
            default: d = '0;
        endcase
        return (d > Q_BITS'(255)) ? 8'd255 : d[7:0];
    endfunction

    logic [7:0] red_reg, green_reg, blue_reg;
    mark_t      m5_reg;
    logic       out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= finish(p_r4_reg, c_r4_reg);
            green_reg <= finish(p_g4_reg, c_g4_reg);
            blue_reg  <= finish(p_b4_reg, c_b4_reg);
            m5_reg    <= m4_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign row_end   = m5_reg.row_end;
    assign frame_end = m5_reg.frame_end;

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(frame_end))
        else $error("output changed while stalled");

    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready with empty output");
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the bilinear Bayer demosaic: streams raw frames, predicts every
// RGB pixel with its own demosaic model and compares the results. Depends on bbd_pkg and the RTL.
module tb_top
    import bbd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        logic        cmd;
        logic [11:0] raw;
    } raw_item_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } rgb_pixel_t;

    logic clk, rst_n;
    logic in_valid, in_ready, cmd;
    logic [11:0] raw_pixel;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic out_valid, out_ready;
    logic [7:0] red, green, blue;
    logic row_end, frame_end;

    bayer_bilinear_demosaic dut (.*);

    // Demosaic shadow state
    logic [11:0] sh_width_reg;
    logic [12:0] sh_height_reg;
    logic        sh_red_row, sh_red_col;
    logic [15:0] sh_gain_r, sh_gain_g, sh_gain_b;
    logic [11:0] upper_line [MAX_WIDTH];
    logic [11:0] lower_line [MAX_WIDTH];
    logic [35:0] window [3];
    int unsigned col_in, row_in, col_out, row_out;

    raw_item_t  pixel_feed[$];
    rgb_pixel_t rgb_expected[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  pixels_seen = 0;
    int  frames_seen = 0;
    int  idle_cycles = 0;
    bit  idle_on = 1;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  in_fire = 0, out_fire = 0;

    function automatic logic [11:0] win_pixel(int k, int j);
        return window[k][12*j +: 12];
    endfunction

    function automatic logic [7:0] channel_value(logic [2:0] kind, bit up, bit dn, bit lf, bit rt,
                                                 logic [15:0] gain);
        longint unsigned sum, v;
        int cnt;
        sum = 0;
        cnt = 0;
        case (kind)
            KIND_COPY: begin sum += win_pixel(1, 1); cnt++; end
            KIND_PLUS: begin
                if (up) begin sum += win_pixel(1, 0); cnt++; end
                if (dn) begin sum += win_pixel(1, 2); cnt++; end
                if (lf) begin sum += win_pixel(0, 1); cnt++; end
                if (rt) begin sum += win_pixel(2, 1); cnt++; end
            end
            KIND_CROSS: begin
                if (up && lf) begin sum += win_pixel(0, 0); cnt++; end
                if (dn && lf) begin sum += win_pixel(0, 2); cnt++; end
                if (up && rt) begin sum += win_pixel(2, 0); cnt++; end
                if (dn && rt) begin sum += win_pixel(2, 2); cnt++; end
            end
            KIND_HORIZ: begin
                if (lf) begin sum += win_pixel(0, 1); cnt++; end
                if (rt) begin sum += win_pixel(2, 1); cnt++; end
            end
            default: begin
                if (up) begin sum += win_pixel(1, 0); cnt++; end
                if (dn) begin sum += win_pixel(1, 2); cnt++; end
            end
        endcase
        if (cnt == 0)
            return 8'd0;
        v = (sum * gain) / (cnt * 1024);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    task automatic demosaic_step(logic c, logic [11:0] raw);
        int unsigned w, h, idx;
        bit done_in, emit, up, dn, lf, rt, rp, cp;
        logic [11:0] px;
        logic [2:0] kr, kg, kb;
        rgb_pixel_t res;
        w = (sh_width_reg < 2) ? 2 : ((sh_width_reg > MAX_WIDTH) ? MAX_WIDTH : sh_width_reg);
        h = (sh_height_reg < 2) ? 2 : sh_height_reg;
        done_in = row_in >= h;
        if (c == CMD_FLUSH && !done_in)
            return;
        px = done_in ? 12'd0 : raw;
        idx = (col_in < MAX_WIDTH) ? col_in : MAX_WIDTH - 1;
        window[0] = window[1];
        window[1] = window[2];
        window[2] = {px, lower_line[idx], upper_line[idx]};
        upper_line[idx] = lower_line[idx];
        lower_line[idx] = px;
        emit = (row_in >= 1 && col_in >= 1) || row_in >= 2;
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        if (!emit)
            return;
        up = row_out > 0;
        dn = row_out + 1 < h;
        lf = col_out > 0;
        rt = col_out + 1 < w;
        rp = row_out[0];
        cp = col_out[0];
        if (rp == sh_red_row && cp == sh_red_col) begin
            kr = KIND_COPY; kg = KIND_PLUS; kb = KIND_CROSS;
        end else if (rp != sh_red_row && cp != sh_red_col) begin
            kr = KIND_CROSS; kg = KIND_PLUS; kb = KIND_COPY;
        end else if (rp != sh_red_row) begin
            kr = KIND_VERT; kg = KIND_COPY; kb = KIND_HORIZ;
        end else begin
            kr = KIND_HORIZ; kg = KIND_COPY; kb = KIND_VERT;
        end
        res.row_end = col_out + 1 >= w;
        res.frame_end = res.row_end && (row_out + 1 >= h);
        res.red = channel_value(kr, up, dn, lf, rt, sh_gain_r);
        res.green = channel_value(kg, up, dn, lf, rt, sh_gain_g);
        res.blue = channel_value(kb, up, dn, lf, rt, sh_gain_b);
        rgb_expected = {rgb_expected, res};
        if (res.frame_end) begin
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        end else if (res.row_end) begin
            col_out = 0;
            row_out++;
        end else begin
            col_out++;
        end
    endtask

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Transfer detection, prediction and checking at the rising edge.
    always @(posedge clk) begin
        in_fire = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (in_fire)
            demosaic_step(cmd, raw_pixel);
        if (out_fire) begin
            pixels_seen++;
            if (frame_end)
                frames_seen++;
            if (rgb_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output pixel r=%0d g=%0d b=%0d", red, green, blue);
            end else begin
                rgb_pixel_t e;
                e = rgb_expected.pop_front();
                if (e.red !== red || e.green !== green || e.blue !== blue ||
                    e.row_end !== row_end || e.frame_end !== frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel %0d: expected r=%0d g=%0d b=%0d re=%0d fe=%0d, ",
                                  "got r=%0d g=%0d b=%0d re=%0d fe=%0d"},
                                 pixels_seen, e.red, e.green, e.blue, e.row_end, e.frame_end,
                                 red, green, blue, row_end, frame_end);
                end
            end
        end
        if (in_fire || out_fire || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Input driver.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pixel_feed.size() > 0) begin
                raw_item_t it;
                it = pixel_feed.pop_front();
                in_valid <= 1'b1;
                cmd <= it.cmd;
                raw_pixel <= it.raw;
                items_sent++;
                gap_left = idle_on ? $urandom_range(0, 11) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output ready, with per-pixel stalls and one long hold-off.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_req) begin
                hold_req = 0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (out_fire) begin
                stall_left = idle_on ? $urandom_range(0, 11) : 0;
                out_ready <= (stall_left == 0);
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= (stall_left == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  sh_width_reg = value[11:0];
            REG_FRAME_HEIGHT: sh_height_reg = value[12:0];
            REG_RED_ROW:      sh_red_row = value[0];
            REG_RED_COL:      sh_red_col = value[0];
            REG_GAIN_RED:     sh_gain_r = value[15:0];
            REG_GAIN_GREEN:   sh_gain_g = value[15:0];
            default:          sh_gain_b = value[15:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_feed.size() != 0 || in_valid || rgb_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_raw();
        case ($urandom_range(0, 5))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic void push_item(logic c, logic [11:0] raw);
        raw_item_t it;
        it.cmd = c;
        it.raw = raw;
        pixel_feed = {pixel_feed, it};
    endfunction

    // One frame of pixels plus the flushes that drain it. With noise on, stray flushes
    // fall inside the frame, some drain slots carry a late pixel, and a stray flush follows.
    task automatic queue_frame(int w, int h, bit noise);
        for (int i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(0, 19) == 0)
                push_item(CMD_FLUSH, pick_raw());
            push_item(CMD_PIXEL, pick_raw());
        end
        for (int i = 0; i <= w; i++) begin
            if (noise && $urandom_range(0, 3) == 0)
                push_item(CMD_PIXEL, pick_raw());
            else
                push_item(CMD_FLUSH, pick_raw());
        end
        if (noise)
            push_item(CMD_FLUSH, pick_raw());
    endtask

    task automatic set_frame(int unsigned wreg, int unsigned hreg, bit rr, bit rc,
                             int unsigned gr, int unsigned gg, int unsigned gb);
        write_reg(REG_FRAME_WIDTH, wreg);
        write_reg(REG_FRAME_HEIGHT, hreg);
        write_reg(REG_RED_ROW, 32'(rr));
        write_reg(REG_RED_COL, 32'(rc));
        write_reg(REG_GAIN_RED, gr);
        write_reg(REG_GAIN_GREEN, gg);
        write_reg(REG_GAIN_BLUE, gb);
    endtask

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2: return 1024;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    initial begin
        int unsigned wreg, hreg, w, h;
        bit did_hold;
        rst_n = 0;
        in_valid = 0; cmd = CMD_PIXEL; raw_pixel = 0;
        cfg_valid = 0; cfg_index = REG_FRAME_WIDTH; cfg_data = 0;
        out_ready = 0;
        sh_width_reg = 640; sh_height_reg = 480; sh_red_row = 0; sh_red_col = 0;
        sh_gain_r = 255; sh_gain_g = 182; sh_gain_b = 255;
        foreach (upper_line[i]) begin
            upper_line[i] = 0;
            lower_line[i] = 0;
        end
        foreach (window[i]) window[i] = 0;
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(posedge clk);

        // Directed: smallest frame, full-scale and zero pixels, flush before any pixel.
        set_frame(2, 2, 1'b0, 1'b0, 1024, 1024, 1024);
        push_item(CMD_FLUSH, 12'hFFF);
        push_item(CMD_PIXEL, 12'hFFF);
        push_item(CMD_PIXEL, 12'h000);
        push_item(CMD_PIXEL, 12'h000);
        push_item(CMD_PIXEL, 12'hFFF);
        push_item(CMD_FLUSH, 12'd0);
        push_item(CMD_PIXEL, 12'hABC);
        push_item(CMD_FLUSH, 12'd0);
        push_item(CMD_FLUSH, 12'd0);
        wait_idle();
        // Saturating gains with the red site moved, then zero gains.
        set_frame(3, 3, 1'b1, 1'b1, 65535, 65535, 65535);
        for (int i = 0; i < 9; i++)
            push_item(CMD_PIXEL, (i % 2) ? 12'hFFF : 12'h001);
        for (int i = 0; i < 4; i++)
            push_item(CMD_FLUSH, 12'd0);
        wait_idle();
        set_frame(1, 0, 1'b0, 1'b1, 0, 0, 0);
        queue_frame(2, 2, 0);
        wait_idle();

        // Random frames.
        did_hold = 0;
        while (items_sent < 1000) begin
            idle_on = $urandom_range(0, 3) != 0;
            wreg = $urandom_range(0, 12);
            hreg = $urandom_range(0, 8);
            w = (wreg < 2) ? 2 : wreg;
            h = (hreg < 2) ? 2 : hreg;
            set_frame(wreg, hreg, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_gain(), pick_gain(), pick_gain());
            for (int f = $urandom_range(1, 2); f > 0; f--)
                queue_frame(w, h, $urandom_range(0, 3) != 0);
            if (!did_hold && items_sent > 400) begin
                hold_req = 1;
                did_hold = 1;
            end
            wait_idle();
        end

        $display("Sent %0d input transfers, checked %0d output pixels over %0d frames.",
                 items_sent, pixels_seen, frames_seen);
        $display("Covered edge frames, red site phases, gain extremes and stray flushes.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
